[hw/rtl/ipdhp_pkg.sv]
// Shared types, constants and character tables for the +IPD header parser.
// Used by every module of the parser; depends on nothing.
package ipdhp_pkg;

   localparam int FIELD_LIMIT_DEF = 11;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CFG_W = 14;
   localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RESET = 14'd10000;

   localparam logic [2:0] MARK_LEN = 3'd5;
   localparam logic [3:0] PATH_LEN = 4'd10;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic STATUS_PARSED  = 1'b0;
   localparam logic STATUS_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LINK   = 3'd1,
      PH_LENGTH = 3'd2,
      PH_METHOD = 3'd3,
      PH_URL    = 3'd4
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  link_id;
      logic [15:0] payload_length;
      logic        url_match;
   } rsp_type;

   // Classified item as handed from the front end to the back end
   typedef struct packed {
      logic       is_tick;
      logic [7:0] data_byte;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_comma;
      logic       is_colon;
      logic       is_space;
   } token_type;

   function automatic logic [7:0] mark_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h2B;  // '+'
         3'd1: c = 8'h49;  // 'I'
         3'd2: c = 8'h50;  // 'P'
         3'd3: c = 8'h44;  // 'D'
         3'd4: c = 8'h2C;  // ','
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] path_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h2F;  // '/'
         4'd1: c = 8'h63;  // 'c'
         4'd2: c = 8'h68;  // 'h'
         4'd3: c = 8'h65;  // 'e'
         4'd4: c = 8'h63;  // 'c'
         4'd5: c = 8'h6B;  // 'k'
         4'd6: c = 8'h5F;  // '_'
         4'd7: c = 8'h64;  // 'd'
         4'd8: c = 8'h68;  // 'h'
         4'd9: c = 8'h74;  // 't'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/ipdhp_front.sv]
// Front end: accepts input items and classifies each into a token.
// Depends on ipdhp_pkg.
module ipdhp_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipdhp_pkg::req_type   req_data,
   input  logic                 q_ready,
   output logic                 q_push,
   output ipdhp_pkg::token_type q_token
);

   logic [7:0] byte_val;

   assign byte_val  = req_data.data_byte;
   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   always_comb begin
      q_token.is_tick   = (req_data.kind == ipdhp_pkg::KIND_TICK);
      q_token.data_byte = byte_val;
      q_token.is_digit  = (byte_val >= ipdhp_pkg::CHAR_ZERO) &&
                          (byte_val <= ipdhp_pkg::CHAR_NINE);
      q_token.digit     = 4'(byte_val - ipdhp_pkg::CHAR_ZERO);
      q_token.is_comma  = (byte_val == ipdhp_pkg::CHAR_COMMA);
      q_token.is_colon  = (byte_val == ipdhp_pkg::CHAR_COLON);
      q_token.is_space  = (byte_val == ipdhp_pkg::CHAR_SPACE);
   end

endmodule

[hw/rtl/ipdhp_queue.sv]
// Short token queue between the front and back ends.
// Depends on ipdhp_pkg for the token type.
module ipdhp_queue #(
   parameter int DEPTH = ipdhp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ipdhp_pkg::token_type push_token,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output ipdhp_pkg::token_type pop_token
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ipdhp_pkg::token_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_token  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CNT_FULL)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/ipdhp_back.sv]
// Back end: header state machine, field accumulation and the result register.
// Depends on ipdhp_pkg.
module ipdhp_back #(
   parameter int FIELD_LIMIT = ipdhp_pkg::FIELD_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ipdhp_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                               q_valid,
   input  ipdhp_pkg::token_type               q_token,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ipdhp_pkg::rsp_type                 rsp_data
);

   localparam logic [3:0] LIMIT = 4'(FIELD_LIMIT);

   ipdhp_pkg::phase_type          phase_ff, phase_in;
   logic [2:0]                    match_idx_ff, match_idx_in;
   logic [3:0]                    field_cnt_ff, field_cnt_in;
   logic [7:0]                    link_acc_ff, link_acc_in;
   logic [15:0]                   len_acc_ff, len_acc_in;
   logic                          digits_done_ff, digits_done_in;
   logic                          url_equal_ff, url_equal_in;
   logic [ipdhp_pkg::CFG_W-1:0]   idle_cnt_ff, idle_cnt_in;
   logic [ipdhp_pkg::CFG_W-1:0]   timeout_ff, timeout_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ipdhp_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [ipdhp_pkg::CFG_W-1:0]   limit_val;
   logic [ipdhp_pkg::CFG_W-1:0]   idle_next;
   logic [3:0]                    field_next;
   logic [7:0]                    link_next;
   logic [19:0]                   len_wide;
   logic                          is_term;
   logic                          ends_field;
   logic                          terminated;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign limit_val  = (timeout_ff == '0) ? ipdhp_pkg::CFG_W'(1) : timeout_ff;
   assign idle_next  = idle_cnt_ff + 1'b1;
   assign field_next = field_cnt_ff + 1'b1;
   assign link_next  = 8'({link_acc_ff, 3'b000} + {link_acc_ff, 1'b0} + {4'b0000, q_token.digit});
   assign len_wide   = {1'b0, len_acc_ff, 3'b000} + {3'b000, len_acc_ff, 1'b0} +
                       {16'h0000, q_token.digit};

   always_comb begin
      case (phase_ff)
         ipdhp_pkg::PH_LINK:   is_term = q_token.is_comma;
         ipdhp_pkg::PH_LENGTH: is_term = q_token.is_colon;
         default:              is_term = q_token.is_space;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      match_idx_in   = match_idx_ff;
      field_cnt_in   = field_cnt_ff;
      link_acc_in    = link_acc_ff;
      len_acc_in     = len_acc_ff;
      digits_done_in = digits_done_ff;
      url_equal_in   = url_equal_ff;
      idle_cnt_in    = idle_cnt_ff;
      timeout_in     = csr_we ? csr_wdata : timeout_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      ends_field     = 1'b0;
      terminated     = 1'b0;

      if (q_pop) begin
         if (q_token.is_tick) begin
            idle_cnt_in = idle_next;
            if (idle_next >= limit_val) begin
               if (phase_ff != ipdhp_pkg::PH_HUNT) begin
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.status          = ipdhp_pkg::STATUS_TIMEOUT;
                  rsp_data_in.link_id         = '0;
                  rsp_data_in.payload_length  = '0;
                  rsp_data_in.url_match       = 1'b0;
                  phase_in                    = ipdhp_pkg::PH_HUNT;
                  field_cnt_in                = '0;
                  link_acc_in                 = '0;
                  len_acc_in                  = '0;
                  digits_done_in              = 1'b0;
                  url_equal_in                = 1'b1;
               end
               match_idx_in = '0;
               idle_cnt_in  = '0;
            end
         end else begin
            idle_cnt_in = '0;
            case (phase_ff)
               ipdhp_pkg::PH_HUNT: begin
                  if (q_token.data_byte == ipdhp_pkg::mark_char(match_idx_ff)) begin
                     if (match_idx_ff == ipdhp_pkg::MARK_LEN - 3'd1) begin
                        match_idx_in = '0;
                        phase_in     = ipdhp_pkg::PH_LINK;
                     end else begin
                        match_idx_in = match_idx_ff + 1'b1;
                     end
                  end else begin
                     match_idx_in = '0;
                  end
               end
               ipdhp_pkg::PH_LINK, ipdhp_pkg::PH_LENGTH,
               ipdhp_pkg::PH_METHOD, ipdhp_pkg::PH_URL: begin
                  if (is_term) begin
                     ends_field = 1'b1;
                     terminated = 1'b1;
                  end else begin
                     if (phase_ff == ipdhp_pkg::PH_LINK || phase_ff == ipdhp_pkg::PH_LENGTH) begin
                        if (!q_token.is_digit) begin
                           digits_done_in = 1'b1;
                        end else if (!digits_done_ff) begin
                           if (phase_ff == ipdhp_pkg::PH_LINK) begin
                              link_acc_in = link_next;
                           end else begin
                              len_acc_in = (len_wide > 20'hFFFF) ? 16'hFFFF : len_wide[15:0];
                           end
                        end
                     end else if (phase_ff == ipdhp_pkg::PH_URL) begin
                        if (field_cnt_ff >= ipdhp_pkg::PATH_LEN ||
                            q_token.data_byte != ipdhp_pkg::path_char(field_cnt_ff)) begin
                           url_equal_in = 1'b0;
                        end
                     end
                     field_cnt_in = field_next;
                     if (field_next >= LIMIT) begin
                        ends_field = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in       = ipdhp_pkg::PH_HUNT;
                  match_idx_in   = '0;
                  field_cnt_in   = '0;
                  link_acc_in    = '0;
                  len_acc_in     = '0;
                  digits_done_in = 1'b0;
                  url_equal_in   = 1'b1;
               end
            endcase

            if (ends_field) begin
               if (phase_ff == ipdhp_pkg::PH_URL) begin
                  // URL closes the header: emit and go back to hunting
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.status         = ipdhp_pkg::STATUS_PARSED;
                  rsp_data_in.link_id        = link_acc_ff;
                  rsp_data_in.payload_length = len_acc_ff;
                  rsp_data_in.url_match      = terminated && url_equal_ff &&
                                               (field_cnt_ff == ipdhp_pkg::PATH_LEN);
                  phase_in                   = ipdhp_pkg::PH_HUNT;
                  match_idx_in               = '0;
                  link_acc_in                = '0;
                  len_acc_in                 = '0;
               end else begin
                  phase_in = ipdhp_pkg::phase_type'(phase_ff + 3'd1);
               end
               field_cnt_in   = '0;
               digits_done_in = 1'b0;
               url_equal_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ipdhp_pkg::PH_HUNT;
         match_idx_ff   <= '0;
         field_cnt_ff   <= '0;
         link_acc_ff    <= '0;
         len_acc_ff     <= '0;
         digits_done_ff <= 1'b0;
         url_equal_ff   <= 1'b1;
         idle_cnt_ff    <= '0;
         timeout_ff     <= ipdhp_pkg::IDLE_TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         match_idx_ff   <= match_idx_in;
         field_cnt_ff   <= field_cnt_in;
         link_acc_ff    <= link_acc_in;
         len_acc_ff     <= len_acc_in;
         digits_done_ff <= digits_done_in;
         url_equal_ff   <= url_equal_in;
         idle_cnt_ff    <= idle_cnt_in;
         timeout_ff     <= timeout_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_timeout_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ipdhp_pkg::STATUS_TIMEOUT |->
      rsp_data_ff.link_id == '0 && rsp_data_ff.payload_length == '0 && !rsp_data_ff.url_match)
      else $error("timeout result carries field data");
   a_emit_to_hunt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !(rsp_valid_ff && !rsp_ready) |=> phase_ff == ipdhp_pkg::PH_HUNT)
      else $error("new result did not return to hunting");
   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ipdhp_pkg::PH_HUNT |->
      field_cnt_ff == '0 && link_acc_ff == '0 && len_acc_ff == '0 && url_equal_ff)
      else $error("field state not cleared while hunting");
`endif

endmodule

[hw/rtl/at_ipd_header_parser_core.sv]
// A completing item passes through the token queue into the back end, which registers the
// result. Throughput: one item per cycle while no held result stalls the back end.
// A held result stalls the back end; the input stalls once the token queue is full.
// Reset is synchronous: the queue empties, parsing returns to hunting, and the idle
// timeout register loads 10000.
// Top level: instantiates ipdhp_front, ipdhp_queue and ipdhp_back; uses ipdhp_pkg.
module at_ipd_header_parser_core #(
   parameter int FIELD_LIMIT = ipdhp_pkg::FIELD_LIMIT_DEF,
   parameter int QUEUE_DEPTH = ipdhp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ipdhp_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ipdhp_pkg::rsp_type            rsp_data,
   input  logic                          csr_we,
   input  logic [ipdhp_pkg::CFG_W-1:0]   csr_wdata
);

   logic                 q_ready;
   logic                 q_push;
   ipdhp_pkg::token_type push_token;
   logic                 q_pop;
   logic                 q_valid;
   ipdhp_pkg::token_type pop_token;

   ipdhp_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_token   (push_token)
   );

   ipdhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_token  (pop_token)
   );

   ipdhp_back #(
      .FIELD_LIMIT (FIELD_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_token   (pop_token),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for at_ipd_header_parser_core: header fields, idle timeouts,
// a long result stall and random modem traffic, all checked by an in-bench parser.
// Depends on ipdhp_pkg and the parser core RTL.
module tb;

   localparam int FIELD_MAX    = ipdhp_pkg::FIELD_LIMIT_DEF;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1200;
   localparam logic [39:0] MARK_TEXT = "+IPD,";
   localparam logic [79:0] PATH_TEXT = 80'h2F63_6865_636B_5F64_6874;

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_TOGGLE
   } ready_mode_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   ipdhp_pkg::req_type          req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   ipdhp_pkg::rsp_type          rsp_data;
   logic                        csr_we;
   logic [ipdhp_pkg::CFG_W-1:0] csr_wdata;

   // parser state as the block should hold it
   logic [ipdhp_pkg::CFG_W-1:0] idle_limit;
   ipdhp_pkg::phase_type        parse_phase;
   logic [2:0]                  mark_pos;
   logic [3:0]                  field_len;
   logic [7:0]                  link_acc;
   logic [15:0]                 length_acc;
   logic                        digits_stopped;
   logic                        url_same;
   logic [ipdhp_pkg::CFG_W-1:0] idle_ticks;

   ipdhp_pkg::rsp_type          headers_due[$];
   logic [7:0]                  header_text[$];
   ipdhp_pkg::rsp_type          got_hdr;
   ipdhp_pkg::rsp_type          want_hdr;
   string                       url_path;
   int                          mismatches = 0;
   int                          items_sent = 0;
   int                          cycle_count = 0;
   int                          burst_left = 0;
   logic                        gaps_on = 1'b1;
   logic                        hold_rsp_req = 1'b0;

   always #5 clock = ~clock;

   at_ipd_header_parser_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   function automatic void restart_hunt();
      parse_phase    = ipdhp_pkg::PH_HUNT;
      mark_pos       = '0;
      idle_ticks     = '0;
      field_len      = '0;
      link_acc       = '0;
      length_acc     = '0;
      digits_stopped = 1'b0;
      url_same       = 1'b1;
   endfunction

   function automatic void close_field(input logic terminated);
      ipdhp_pkg::rsp_type hdr;
      if (parse_phase == ipdhp_pkg::PH_URL) begin
         hdr.status         = ipdhp_pkg::STATUS_PARSED;
         hdr.link_id        = link_acc;
         hdr.payload_length = length_acc;
         hdr.url_match      = terminated && url_same && (field_len == ipdhp_pkg::PATH_LEN);
         headers_due.push_back(hdr);
         restart_hunt();
      end else begin
         parse_phase    = ipdhp_pkg::phase_type'(parse_phase + 3'd1);
         field_len      = '0;
         digits_stopped = 1'b0;
         url_same       = 1'b1;
      end
   endfunction

   // Advance the parser by one accepted item and queue any header it completes.
   function automatic void predict_header(input ipdhp_pkg::req_type item);
      logic [ipdhp_pkg::CFG_W-1:0] limit;
      logic [7:0]                  ch;
      logic [7:0]                  stop_char;
      logic                        is_digit;
      logic [31:0]                 wide;
      ipdhp_pkg::rsp_type          hdr;
      ch = item.data_byte;
      if (item.kind == ipdhp_pkg::KIND_TICK) begin
         limit = (idle_limit == '0) ? ipdhp_pkg::CFG_W'(1) : idle_limit;
         idle_ticks = idle_ticks + 1'b1;
         if (idle_ticks >= limit) begin
            if (parse_phase == ipdhp_pkg::PH_HUNT) begin
               mark_pos   = '0;
               idle_ticks = '0;
            end else begin
               hdr        = '0;
               hdr.status = ipdhp_pkg::STATUS_TIMEOUT;
               headers_due.push_back(hdr);
               restart_hunt();
            end
         end
      end else begin
         idle_ticks = '0;
         if (parse_phase == ipdhp_pkg::PH_HUNT) begin
            // a failing byte drops the partial mark and is not tried again
            if (ch == MARK_TEXT[8*(4-int'(mark_pos)) +: 8]) begin
               mark_pos = mark_pos + 1'b1;
               if (mark_pos == ipdhp_pkg::MARK_LEN) begin
                  restart_hunt();
                  parse_phase = ipdhp_pkg::PH_LINK;
               end
            end else begin
               mark_pos = '0;
            end
         end else begin
            case (parse_phase)
               ipdhp_pkg::PH_LINK:   stop_char = ipdhp_pkg::CHAR_COMMA;
               ipdhp_pkg::PH_LENGTH: stop_char = ipdhp_pkg::CHAR_COLON;
               default:              stop_char = ipdhp_pkg::CHAR_SPACE;
            endcase
            if (ch == stop_char) begin
               close_field(1'b1);
            end else begin
               is_digit = (ch >= ipdhp_pkg::CHAR_ZERO) && (ch <= ipdhp_pkg::CHAR_NINE);
               if (parse_phase == ipdhp_pkg::PH_LINK ||
                   parse_phase == ipdhp_pkg::PH_LENGTH) begin
                  if (!is_digit) begin
                     digits_stopped = 1'b1;
                  end else if (!digits_stopped) begin
                     if (parse_phase == ipdhp_pkg::PH_LINK) begin
                        link_acc = link_acc * 8'd10 + (ch - ipdhp_pkg::CHAR_ZERO);
                     end else begin
                        wide = length_acc * 32'd10 + (ch - ipdhp_pkg::CHAR_ZERO);
                        length_acc = (wide > 32'd65535) ? 16'hFFFF : wide[15:0];
                     end
                  end
               end else if (parse_phase == ipdhp_pkg::PH_URL) begin
                  if (field_len >= ipdhp_pkg::PATH_LEN) begin
                     url_same = 1'b0;
                  end else if (ch != PATH_TEXT[8*(9-int'(field_len)) +: 8]) begin
                     url_same = 1'b0;
                  end
               end
               field_len = field_len + 1'b1;
               if (field_len >= FIELD_MAX) begin
                  close_field(1'b0);
               end
            end
         end
      end
   endfunction

   task automatic send_item(input logic kind, input logic [7:0] data);
      ipdhp_pkg::req_type item;
      item.kind      = kind;
      item.data_byte = data;
      if (gaps_on && burst_left == 0) begin
         repeat ($urandom_range(1, 10)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_header(item);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(ipdhp_pkg::KIND_BYTE, s[i]);
      end
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(ipdhp_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Write only once the parser is quiet: all headers in and the pipeline drained.
   task automatic write_idle_limit(input logic [ipdhp_pkg::CFG_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (headers_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      idle_limit = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         header_text.push_back(s[i]);
      end
   endfunction

   function automatic void put_digits(input int count);
      repeat (count) header_text.push_back(ipdhp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void put_noise(input int count);
      repeat (count) header_text.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Mostly well-formed headers with random content; some broken, cut short or noisy.
   task automatic send_random_header(input int tick_span);
      int pick;
      int cut;
      header_text.delete();
      put_noise($urandom_range(0, 3));
      put_text("+IPD,");
      pick = $urandom_range(0, 11);
      put_digits(pick == 0 ? $urandom_range(9, 12) : $urandom_range(0, 3));
      if (pick == 1) put_noise(1);
      if (pick != 2) header_text.push_back(ipdhp_pkg::CHAR_COMMA);
      put_digits(pick == 3 ? $urandom_range(6, 12) : $urandom_range(0, 5));
      if (pick == 4) put_noise(1);
      header_text.push_back(ipdhp_pkg::CHAR_COLON);
      case ($urandom_range(0, 4))
         0: put_text("GET");
         1: put_text("POST");
         2: put_text("HEAD");
         3: put_noise($urandom_range(0, 13));
         default: ;
      endcase
      header_text.push_back(ipdhp_pkg::CHAR_SPACE);
      case ($urandom_range(0, 5))
         0, 1, 2: put_text(url_path);
         3: begin
            cut = $urandom_range(0, 9);
            for (int i = 0; i < cut; i++) begin
               header_text.push_back(PATH_TEXT[8*(9-i) +: 8]);
            end
         end
         4: begin
            put_text(url_path);
            header_text[header_text.size() - 1 - $urandom_range(0, 9)] =
               8'($urandom_range(0, 255));
         end
         default: begin
            put_text(url_path);
            put_noise($urandom_range(1, 3));
         end
      endcase
      if (pick != 5) header_text.push_back(ipdhp_pkg::CHAR_SPACE);
      if (pick == 6) begin
         cut = $urandom_range(1, header_text.size());
         while (header_text.size() > cut) void'(header_text.pop_back());
      end
      foreach (header_text[i]) begin
         if ($urandom_range(0, 99) < 6) send_ticks($urandom_range(1, tick_span));
         send_item(ipdhp_pkg::KIND_BYTE, header_text[i]);
      end
   endtask

   task automatic test_header_fields();
      gaps_on = 1'b1;
      send_text({"+IPD,0,512:GET ", url_path, " HTTP/1.1"});
      // second plus breaks the mark and is not retried
      send_text({"++IPD,1,1:G ", url_path, " "});
      send_text({"+IPD,255,65535:POST ", url_path, " "});
      // link id keeps its low bits, length saturates
      send_text({"+IPD,300,99999:GET ", url_path.substr(0, 8), " "});
      // digits stop at the first non-digit; the URL ends at the field limit
      send_text({"+IPD,12a3,-5:G ", url_path, "x "});
      // overlong link id spills into the length field
      send_text({"+IPD,12345678901,7:GET ", url_path, " "});
      send_text("+IPD, 5,10:GET / ");
      send_text({"+IPD,2,3:ABCDEFGHIJK", url_path, " "});
      send_text("+IPD,3,4:GET  ");
   endtask

   task automatic test_idle_timeouts();
      gaps_on = 1'b0;
      // well below the reset limit: no timeout
      send_text("+IPD,7");
      send_ticks(40);
      write_idle_limit(14'h3FFF);
      send_text("+IPD,1,2:GE");
      send_ticks(40);
      write_idle_limit(14'd3);
      // close the open header by timeout
      send_ticks(3);
      // idle while hunting drops the partial mark
      send_text("+IP");
      send_ticks(3);
      send_text({"D,1,2:G ", url_path, " "});
      send_text("+IP");
      send_ticks(2);
      send_text({"D,5,6:G ", url_path, " "});
      send_text("+IPD,4");
      send_ticks(2);
      send_text("2,8:");
      send_ticks(2);
      send_text({"G ", url_path});
      send_ticks(3);
      write_idle_limit('0);
      send_text("+IPD,9");
      send_ticks(2);
      write_idle_limit(14'd1);
      send_text("+IPD,9,1:");
      send_ticks(1);
      gaps_on = 1'b1;
   endtask

   task automatic test_result_backpressure();
      gaps_on      = 1'b0;
      hold_rsp_req = 1'b1;
      repeat (12) send_text({"+IPD,1,4:G ", url_path, " "});
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [ipdhp_pkg::CFG_W-1:0] settings [6];
      int                          goal;
      int                          span;
      settings[0] = 14'd1;
      settings[1] = '0;
      settings[2] = 14'($urandom_range(2, 30));
      settings[3] = 14'h3FFF;
      settings[4] = 14'($urandom_range(2, 60));
      settings[5] = ipdhp_pkg::IDLE_TIMEOUT_RESET;
      gaps_on = 1'b1;
      foreach (settings[r]) begin
         write_idle_limit(settings[r]);
         span = (int'(settings[r]) < 40) ? int'(settings[r]) + 2 : 40;
         goal = items_sent + RANDOM_ITEMS / 6;
         while (items_sent < goal) send_random_header(span);
      end
   endtask

   // Receiver: its own stall pattern, plus a long hold-off on request.
   initial begin : rsp_stall_pattern
      int             hold_left;
      int             mode_left;
      ready_mode_type mode;
      hold_left = 0;
      mode_left = 0;
      mode      = READY_ALWAYS;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_RARELY: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= mode_left[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_hdr = rsp_data;
         if (headers_due.size() == 0) begin
            $error("unexpected header: status %0d link_id %0d payload_length %0d url_match %0d",
                   got_hdr.status, got_hdr.link_id, got_hdr.payload_length,
                   got_hdr.url_match);
            mismatches++;
         end else begin
            want_hdr = headers_due.pop_front();
            if (got_hdr.status !== want_hdr.status) begin
               $error("status: expected %0d, got %0d", want_hdr.status, got_hdr.status);
               mismatches++;
            end
            if (got_hdr.link_id !== want_hdr.link_id) begin
               $error("link_id: expected %0d, got %0d", want_hdr.link_id, got_hdr.link_id);
               mismatches++;
            end
            if (got_hdr.payload_length !== want_hdr.payload_length) begin
               $error("payload_length: expected %0d, got %0d",
                      want_hdr.payload_length, got_hdr.payload_length);
               mismatches++;
            end
            if (got_hdr.url_match !== want_hdr.url_match) begin
               $error("url_match: expected %0d, got %0d",
                      want_hdr.url_match, got_hdr.url_match);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("at_ipd_header_parser_core: mismatch");
         $finish;
      end
   end

   initial begin
      int spin;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      idle_limit = ipdhp_pkg::IDLE_TIMEOUT_RESET;
      url_path   = $sformatf("%s", PATH_TEXT);
      restart_hunt();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_header_fields();
      test_idle_timeouts();
      test_result_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      spin = 0;
      while (headers_due.size() != 0 && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (headers_due.size() != 0) begin
         $error("%0d expected headers never arrived", headers_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("at_ipd_header_parser_core: match");
      end else begin
         $display("at_ipd_header_parser_core: mismatch");
      end
      $finish;
   end

endmodule
